// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Command word passed from front to back, opcodes, state codes, defaults.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;
  localparam int QUEUE_DEPTH = 2;

  // fixed field widths (ROWS <= 32, COLUMNS <= 128)
  localparam int LINE_W   = 5;
  localparam int COLIDX_W = 7;
  localparam int IDX_W    = 11;
  localparam int CELL_W   = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0F20;  // space, white on black
  localparam logic [7:0]        CHAR_NL    = 8'h0A;
  localparam logic [7:0]        CHAR_CR    = 8'h0D;

  localparam logic [1:0] MODE_BEGIN = 2'd0;
  localparam logic [1:0] MODE_CHAR  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_READ  = 2'd3;

  typedef enum logic [2:0] {
    OP_BEGIN_OK,
    OP_BEGIN_BAD,
    OP_NEWLINE,
    OP_RETURN,
    OP_PRINT,
    OP_CLEAR,
    OP_READ
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t               op;
    logic [LINE_W-1:0]     line;
    logic [7:0]            ch;
    logic [7:0]            color;
    logic [IDX_W-1:0]      rd_index;
    logic [LINE_W-1:0]     rd_row;
    logic [COLIDX_W-1:0]   rd_col;
    logic                  rd_ok;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_FILL,
    ST_READ
  } back_state_t;

  typedef enum logic [1:0] {
    RD_MEM,
    RD_BLANK,
    RD_ZERO
  } rd_src_t;

endpackage

// ----- rtl/tcw_stream_if.sv -----
// ----------------------------------------------------------------------------
// tcw_stream_if: valid/ready channels of the text console writer
// Input word channel and result word channel.
// ----------------------------------------------------------------------------
interface tcw_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic signed [7:0] start_line;
  logic [7:0]        char_code;
  logic [7:0]        color;
  logic [10:0]       read_index;

  modport source (output valid, mode, start_line, char_code, color, read_index,
                  input ready);
  modport sink   (input valid, mode, start_line, char_code, color, read_index,
                  output ready);
endinterface

interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [4:0]  next_line;
  logic        cell_written;
  logic [10:0] cell_index;
  logic [15:0] cell_value;
  logic [10:0] cursor_pos;
  logic        scrolled;

  modport source (output valid, status, next_line, cell_written, cell_index,
                         cell_value, cursor_pos, scrolled,
                  input ready);
  modport sink   (input valid, status, next_line, cell_written, cell_index,
                        cell_value, cursor_pos, scrolled,
                  output ready);
endinterface

// ----- rtl/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/tcw_fifo.sv -----
// ----------------------------------------------------------------------------
// tcw_fifo: short command queue between front and back
// Register-based FIFO, push and pop in the same cycle allowed.
// ----------------------------------------------------------------------------
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- rtl/tcw_front.sv -----
// ----------------------------------------------------------------------------
// tcw_front: input stage of the text console writer
// Takes input words, classifies them and splits read indexes into row/col.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  tcw_in_if.sink        in_ch,
  output logic          push,
  output tcw_pkg::cmd_t push_cmd,
  input  logic          q_full
);

  import tcw_pkg::*;

  // row = index / COLUMNS by reciprocal, estimate is exact or one short
  localparam int SHIFT  = 18;
  localparam int RECIP  = (1 << SHIFT) / COLUMNS;
  localparam int PROD_W = SHIFT + IDX_W;
  localparam int REM_W  = IDX_W + 1;
  localparam int CELLS  = ROWS * COLUMNS;

  logic              s1_valid_r, s1_valid_nxt;
  logic [1:0]        mode_r;
  logic [7:0]        line_r;
  logic [7:0]        ch_r;
  logic [7:0]        color_r;
  logic [IDX_W-1:0]  idx_r;
  logic [PROD_W-1:0] prod_r;
  logic              accept;

  logic [IDX_W-1:0]  est;
  logic [REM_W-1:0]  est_c;
  logic [REM_W-1:0]  rem;
  logic [IDX_W-1:0]  row;
  logic [REM_W-1:0]  col;

  assign in_ch.ready = !s1_valid_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = s1_valid_r && !q_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_ch.mode;
      line_r  <= in_ch.start_line;
      ch_r    <= in_ch.char_code;
      color_r <= in_ch.color;
      idx_r   <= in_ch.read_index;
      prod_r  <= PROD_W'(in_ch.read_index) * PROD_W'(RECIP);
    end
  end

  // one correction step on the row estimate
  always_comb begin
    est   = prod_r[PROD_W-1:SHIFT];
    est_c = REM_W'(est) * REM_W'(COLUMNS);
    rem   = {1'b0, idx_r} - est_c;
    if (rem >= REM_W'(COLUMNS)) begin
      row = est + 1'b1;
      col = rem - REM_W'(COLUMNS);
    end else begin
      row = est;
      col = rem;
    end
  end

  always_comb begin
    push_cmd.op       = OP_READ;
    push_cmd.line     = line_r[LINE_W-1:0];
    push_cmd.ch       = ch_r;
    push_cmd.color    = color_r;
    push_cmd.rd_index = idx_r;
    push_cmd.rd_row   = row[LINE_W-1:0];
    push_cmd.rd_col   = col[COLIDX_W-1:0];
    push_cmd.rd_ok    = (32'(idx_r) < 32'(CELLS));
    case (mode_r)
      MODE_BEGIN: begin
        if (!line_r[7] && (line_r[6:0] < 7'(ROWS))) begin
          push_cmd.op = OP_BEGIN_OK;
        end else begin
          push_cmd.op = OP_BEGIN_BAD;
        end
      end
      MODE_CHAR: begin
        if (ch_r == CHAR_NL) begin
          push_cmd.op = OP_NEWLINE;
        end else if (ch_r == CHAR_CR) begin
          push_cmd.op = OP_RETURN;
        end else begin
          push_cmd.op = OP_PRINT;
        end
      end
      MODE_CLEAR: push_cmd.op = OP_CLEAR;
      MODE_READ:  push_cmd.op = OP_READ;
      default:    push_cmd.op = OP_READ;
    endcase
  end

endmodule

// ----- rtl/tcw_back.sv -----
// ----------------------------------------------------------------------------
// tcw_back: execution stage of the text console writer
// Owns position, screen RAM with per-row valid bits, row rotation and result.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  tcw_pkg::cmd_t q_cmd,
  output logic          pop,
  tcw_out_if.source     out_ch
);

  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int POS_W  = ADDR_W + 1;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CNT_W  = $clog2(COLUMNS + 1);
  localparam int FILL_W = $clog2(COLUMNS);
  localparam int SUM_W  = LINE_W + 1;

  back_state_t       state_r, state_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  logic [CNT_W-1:0]  col_r, col_nxt;
  logic              drop_r, drop_nxt;
  logic [IDX_W-1:0]  cursor_r, cursor_nxt;
  logic [LINE_W-1:0] base_r, base_nxt;
  logic [ROWS-1:0]   rvalid_r, rvalid_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [7:0]        ch_r, ch_nxt;
  logic [7:0]        color_r, color_nxt;
  logic              scr_r, scr_nxt;
  rd_src_t           rsrc_r, rsrc_nxt;
  logic [IDX_W-1:0]  ridx_r, ridx_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              o_status_r, o_written_r, o_scr_r;
  logic [4:0]        o_next_r;
  logic [IDX_W-1:0]  o_idx_r, o_cursor_r;
  logic [CELL_W-1:0] o_val_r;

  logic              ld;
  logic              ld_status, ld_written, ld_scr;
  logic [4:0]        ld_next;
  logic [IDX_W-1:0]  ld_idx, ld_cursor;
  logic [CELL_W-1:0] ld_val;

  logic              out_free;
  logic [LINE_W-1:0] wrow, rrow;
  logic [POS_W-1:0]  lpos;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  // logical row to physical row under the scroll rotation
  function automatic logic [LINE_W-1:0] phys_row(input logic [LINE_W-1:0] row,
                                                 input logic [LINE_W-1:0] base);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(row) + SUM_W'(base);
    if (sum >= SUM_W'(ROWS)) begin
      sum = sum - SUM_W'(ROWS);
    end
    return sum[LINE_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [LINE_W-1:0] prow,
                                                  input logic [CNT_W-1:0] col);
    return ADDR_W'(POS_W'(prow) * POS_W'(COLUMNS) + POS_W'(col));
  endfunction

  assign out_free = !out_valid_r || out_ch.ready;
  assign pop      = (state_r == ST_IDLE) && q_valid && out_free;
  assign wrow     = phys_row(line_r, base_r);
  assign rrow     = phys_row(q_cmd.rd_row, base_r);
  assign lpos     = POS_W'(line_r) * POS_W'(COLUMNS) + POS_W'(col_r);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (q_cmd.op)
            OP_PRINT: if (!drop_r) state_nxt = ST_WRITE;
            OP_READ:  state_nxt = ST_READ;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WRITE: begin
        if (!rvalid_r[wrow[ROW_W-1:0]]) begin
          state_nxt = ST_FILL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (fill_r == FILL_W'(COLUMNS - 1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    line_nxt   = line_r;
    col_nxt    = col_r;
    drop_nxt   = drop_r;
    cursor_nxt = cursor_r;
    base_nxt   = base_r;
    rvalid_nxt = rvalid_r;
    fill_nxt   = fill_r;
    ch_nxt     = ch_r;
    color_nxt  = color_r;
    scr_nxt    = scr_r;
    rsrc_nxt   = rsrc_r;
    ridx_nxt   = ridx_r;

    ram_we     = 1'b0;
    ram_waddr  = cell_addr(wrow, col_r);
    ram_wdata  = {color_r, ch_r};
    ram_re     = 1'b0;
    ram_raddr  = cell_addr(rrow, CNT_W'(q_cmd.rd_col));

    ld         = 1'b0;
    ld_status  = 1'b0;
    ld_next    = LINE_W'(line_r + 1'b1);
    ld_written = 1'b0;
    ld_idx     = '0;
    ld_val     = '0;
    ld_cursor  = cursor_r;
    ld_scr     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (q_cmd.op)
            OP_BEGIN_OK: begin
              line_nxt = q_cmd.line;
              col_nxt  = '0;
              drop_nxt = 1'b0;
              ld       = 1'b1;
              ld_next  = LINE_W'(q_cmd.line + 1'b1);
            end
            OP_BEGIN_BAD: begin
              drop_nxt  = 1'b1;
              ld        = 1'b1;
              ld_status = 1'b1;
              ld_next   = '0;
            end
            OP_NEWLINE, OP_RETURN, OP_PRINT: begin
              scr_nxt = 1'b0;
              if (drop_r) begin
                ld        = 1'b1;
                ld_status = 1'b1;
                ld_next   = '0;
              end else begin
                if ((q_cmd.op == OP_NEWLINE) ||
                    ((q_cmd.op == OP_PRINT) && (col_r >= CNT_W'(COLUMNS)))) begin
                  col_nxt = '0;
                  if (line_r == LINE_W'(ROWS - 1)) begin
                    // scroll: old top row turns into the blank bottom row
                    rvalid_nxt[base_r[ROW_W-1:0]] = 1'b0;
                    base_nxt = (base_r == LINE_W'(ROWS - 1)) ? '0 : base_r + 1'b1;
                    scr_nxt  = 1'b1;
                  end else begin
                    line_nxt = line_r + 1'b1;
                  end
                end else if (q_cmd.op == OP_RETURN) begin
                  col_nxt = '0;
                end
                if (q_cmd.op == OP_PRINT) begin
                  ch_nxt    = q_cmd.ch;
                  color_nxt = q_cmd.color;
                end else begin
                  ld      = 1'b1;
                  ld_next = LINE_W'(line_nxt + 1'b1);
                  ld_scr  = scr_nxt;
                end
              end
            end
            OP_CLEAR: begin
              rvalid_nxt = '0;
              cursor_nxt = IDX_W'(CELLS - 1);
              ld         = 1'b1;
              ld_cursor  = IDX_W'(CELLS - 1);
            end
            OP_READ: begin
              ridx_nxt = q_cmd.rd_index;
              if (!q_cmd.rd_ok) begin
                rsrc_nxt = RD_ZERO;
              end else if (rvalid_r[rrow[ROW_W-1:0]]) begin
                rsrc_nxt = RD_MEM;
                ram_re   = 1'b1;
              end else begin
                rsrc_nxt = RD_BLANK;
              end
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end
      ST_WRITE: begin
        if (!rvalid_r[wrow[ROW_W-1:0]]) begin
          fill_nxt = '0;
        end else begin
          ram_we     = 1'b1;
          cursor_nxt = IDX_W'(lpos);
          col_nxt    = col_r + 1'b1;
          ld         = 1'b1;
          ld_written = 1'b1;
          ld_idx     = IDX_W'(lpos);
          ld_val     = {color_r, ch_r};
          ld_cursor  = IDX_W'(lpos);
          ld_scr     = scr_r;
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(wrow, CNT_W'(fill_r));
        ram_wdata = BLANK_CELL;
        fill_nxt  = fill_r + 1'b1;
        if (fill_r == FILL_W'(COLUMNS - 1)) begin
          rvalid_nxt[wrow[ROW_W-1:0]] = 1'b1;
        end
      end
      ST_READ: begin
        ld     = 1'b1;
        ld_idx = ridx_r;
        case (rsrc_r)
          RD_MEM:   ld_val = ram_rdata;
          RD_BLANK: ld_val = BLANK_CELL;
          RD_ZERO:  ld_val = '0;
          default:  ld_val = '0;
        endcase
      end
      default: begin
        ld = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      line_r      <= '0;
      col_r       <= '0;
      drop_r      <= 1'b0;
      cursor_r    <= '0;
      base_r      <= '0;
      rvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      line_r      <= line_nxt;
      col_r       <= col_nxt;
      drop_r      <= drop_nxt;
      cursor_r    <= cursor_nxt;
      base_r      <= base_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fill_r  <= fill_nxt;
    ch_r    <= ch_nxt;
    color_r <= color_nxt;
    scr_r   <= scr_nxt;
    rsrc_r  <= rsrc_nxt;
    ridx_r  <= ridx_nxt;
    if (ld) begin
      o_status_r  <= ld_status;
      o_next_r    <= ld_next;
      o_written_r <= ld_written;
      o_idx_r     <= ld_idx;
      o_val_r     <= ld_val;
      o_cursor_r  <= ld_cursor;
      o_scr_r     <= ld_scr;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.next_line    = o_next_r;
  assign out_ch.cell_written = o_written_r;
  assign out_ch.cell_index   = o_idx_r;
  assign out_ch.cell_value   = o_val_r;
  assign out_ch.cursor_pos   = o_cursor_r;
  assign out_ch.scrolled     = o_scr_r;

endmodule

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer: ROWS x COLUMNS text console with cell readback
// Front classifies words, a two-entry queue decouples it from the back end.
// ----------------------------------------------------------------------------
// The front registers each word, then queues it. The back end settles begin,
//   newline, return, clear and dropped chars in idle, printed chars via a write
//   state, reads via a read state, and takes no new word until back in idle or
//   while a result waits on the output. A char landing in a row not yet blanked
//   since reset, clear or scroll first costs a row fill and a retried write.
// Reset: synchronous, active low; clears position, cursor and all row valid
//   bits, so no clearing pass is needed and input is taken at once.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch
);

  import tcw_pkg::*;

  localparam int CMD_W = $bits(cmd_t);

  // front to queue
  logic  push;
  cmd_t  push_cmd;
  logic  q_full;

  // queue to back end
  logic  q_valid;
  cmd_t  q_cmd;
  logic  pop;

  // classifies each word; read indexes are split into row and column here
  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // lets the front keep taking words while the back end fills a row
  tcw_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_cmd),
    .not_empty (q_valid)
  );

  // screen RAM is addressed by physical row; a scroll rotates the row base
  // and marks the new bottom row blank instead of moving any cells
  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
